>>> sv/fpr_pkg.sv
// Shared constants, codes and the CRC-16 byte update for the framed packet receiver.
package fpr_pkg;

  // Framing bytes and CRC polynomial.
  localparam logic [7:0]  START_BYTE = 8'h5a;
  localparam logic [7:0]  PING_TYPE  = 8'ha6;
  localparam logic [15:0] CRC_POLY   = 16'h1021;

  // Reset value of the expected packet type register.
  localparam logic [7:0]  EXPECTED_TYPE_RST = 8'ha4;

  // Default payload limit and the matching length width.
  localparam int unsigned MAX_PAYLOAD_DEF = 32;
  localparam int unsigned LEN_W_DEF       = $clog2(MAX_PAYLOAD_DEF + 1);

  // Event codes reported with each result item.
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_PING    = 2'd1;
  localparam logic [1:0] EV_GOOD    = 2'd2;
  localparam logic [1:0] EV_CRC_ERR = 2'd3;

  // One byte of CRC-16, MSB first, unrolled over the eight bits.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

>>> sv/fpr_ifs.sv
// Valid/ready channel interfaces for received bytes and result items.
interface fpr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface fpr_res_if import fpr_pkg::*; #(
  parameter int unsigned LEN_W = LEN_W_DEF
);
  logic             valid;
  logic             ready;
  logic [1:0]       event_res;
  logic [7:0]       payload_byte;
  logic             payload_valid;
  logic [LEN_W-1:0] payload_length;

  modport source(output valid, output event_res, output payload_byte,
                 output payload_valid, output payload_length, input ready);
  modport sink(input valid, input event_res, input payload_byte,
               input payload_valid, input payload_length, output ready);
endinterface

>>> sv/framed_packet_receiver_crc16.sv
// Framed packet receiver: start/type/length/CRC header parse, payload pass-through, CRC-16 check.
// Each accepted byte leaves its result item in the output register.
// Throughput: one byte per cycle while result.ready is high; the CRC-16 byte update is a single unrolled step.
// The output register decouples the sides: a byte is taken whenever the register is
// empty or its item is taken in the same cycle.
// Reset (rst, synchronous): hunting for the start byte, counters and CRCs cleared,
// expected type 0xa4, output register empty.
module framed_packet_receiver_crc16 import fpr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  fpr_rx_if.sink     rx,
  fpr_res_if.source  result
);

  localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [15:0] MAX_LEN16 = 16'(MAX_PAYLOAD);

  // Phase codes.
  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_TYPE = 3'd1;
  localparam logic [2:0] PH_LEN0 = 3'd2;
  localparam logic [2:0] PH_LEN1 = 3'd3;
  localparam logic [2:0] PH_CRC0 = 3'd4;
  localparam logic [2:0] PH_CRC1 = 3'd5;
  localparam logic [2:0] PH_DATA = 3'd6;

  logic [7:0]       expected_type;
  logic [2:0]       phase, phase_next;
  logic [LEN_W-1:0] byte_count, byte_count_next;
  logic [LEN_W-1:0] length_field, length_field_next;
  logic [7:0]       len_lo, len_lo_next;
  logic [15:0]      running_crc, running_crc_next;
  logic [15:0]      received_crc, received_crc_next;

  logic             out_valid;
  logic [1:0]       out_event, ev;
  logic [7:0]       out_pbyte, pbyte;
  logic             out_pvalid, pvalid;
  logic [LEN_W-1:0] out_plen, plen;

  logic             accept;
  logic [7:0]       b;
  logic [15:0]      crc_base, crc_upd, len_full;
  logic [LEN_W-1:0] count_inc;
  logic             done;

  assign rx.ready = !out_valid || result.ready;
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;

  // One shared CRC update; a start byte restarts it from zero.
  assign crc_base = (phase == PH_TYPE || phase == PH_LEN0 || phase == PH_LEN1 ||
                     phase == PH_DATA) ? running_crc : 16'h0000;
  assign crc_upd   = crc16_byte(crc_base, b);
  assign len_full  = {b, len_lo};
  assign count_inc = byte_count + LEN_W'(1);

  // Next state and result for the byte on the input.
  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    length_field_next = length_field;
    len_lo_next       = len_lo;
    running_crc_next  = running_crc;
    received_crc_next = received_crc;
    ev     = EV_NONE;
    pbyte  = 8'h00;
    pvalid = 1'b0;
    plen   = '0;
    done   = 1'b0;
    unique case (phase)
      PH_TYPE: begin
        if (b == PING_TYPE) begin
          ev         = EV_PING;
          phase_next = PH_HUNT;
        end else if (b == expected_type) begin
          running_crc_next = crc_upd;
          phase_next       = PH_LEN0;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_LEN0: begin
        running_crc_next = crc_upd;
        len_lo_next      = b;
        phase_next       = PH_LEN1;
      end
      PH_LEN1: begin
        running_crc_next  = crc_upd;
        length_field_next = (len_full > MAX_LEN16) ? LEN_W'(MAX_PAYLOAD)
                                                   : len_full[LEN_W-1:0];
        phase_next        = PH_CRC0;
      end
      PH_CRC0: begin
        received_crc_next = {8'h00, b};
        phase_next        = PH_CRC1;
      end
      PH_CRC1: begin
        received_crc_next = {b, received_crc[7:0]};
        byte_count_next   = '0;
        if (length_field == '0) begin
          done = 1'b1;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        running_crc_next = crc_upd;
        pvalid           = 1'b1;
        pbyte            = b;
        byte_count_next  = count_inc;
        done             = (count_inc >= length_field);
      end
      default: begin
        if (b == START_BYTE) begin
          running_crc_next = crc_upd;
          byte_count_next  = '0;
          phase_next       = PH_TYPE;
        end else begin
          phase_next = PH_HUNT;
        end
      end
    endcase
    // Packet end: compare against the received CRC.
    if (done) begin
      ev         = (running_crc_next == received_crc_next) ? EV_GOOD : EV_CRC_ERR;
      plen       = length_field_next;
      phase_next = PH_HUNT;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_type <= EXPECTED_TYPE_RST;
    end else if (cfg_wr_en) begin
      expected_type <= cfg_wr_data;
    end
  end

  // Parser state, updated on each accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      byte_count   <= '0;
      length_field <= '0;
      len_lo       <= 8'h00;
      running_crc  <= 16'h0000;
      received_crc <= 16'h0000;
    end else if (accept) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      length_field <= length_field_next;
      len_lo       <= len_lo_next;
      running_crc  <= running_crc_next;
      received_crc <= received_crc_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_event  <= ev;
      out_pbyte  <= pbyte;
      out_pvalid <= pvalid;
      out_plen   <= plen;
    end
  end

  assign result.valid          = out_valid;
  assign result.event_res      = out_event;
  assign result.payload_byte   = out_pbyte;
  assign result.payload_valid  = out_pvalid;
  assign result.payload_length = out_plen;

`ifndef SYNTHESIS
  // An accepted byte always leaves a result item in the output register.
  a_accept_fills : assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted byte produced no result item");

  // Length is reported only with a packet event.
  a_len_with_event : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_event != EV_GOOD && out_event != EV_CRC_ERR) |-> out_plen == '0)
    else $error("payload length without packet event");

  // Payload byte is zero unless flagged as payload.
  a_pbyte_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_pvalid) |-> out_pbyte == 8'h00)
    else $error("payload byte set without payload valid");

  // While in the payload the count stays below a nonzero clamped length.
  a_data_count : assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (length_field != '0 && byte_count < length_field &&
                            length_field <= LEN_W'(MAX_PAYLOAD)))
    else $error("payload count out of range");

  // A ping is only reported for the byte after a start byte.
  a_ping_origin : assert property (@(posedge clk) disable iff (rst)
    (accept && ev == EV_PING) |-> phase == PH_TYPE)
    else $error("ping reported outside the type byte");
`endif

endmodule
